/* design/assert_macros.svh */
// Concurrent assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/ipv4p_pkg.sv */
// Types and constants of the IPv4 dotted text parser.
package ipv4p_pkg;

	localparam logic [16:0] OCTET_LIMIT = 17'd255;
	localparam logic [16:0] PORT_LIMIT  = 17'd65535;
	localparam logic [16:0] ACC_SAT     = 17'd65536;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_OCT0  = 3'd0,
		PH_OCT1  = 3'd1,
		PH_OCT2  = 3'd2,
		PH_OCT3  = 3'd3,
		PH_PORT  = 3'd4,
		PH_DONE  = 3'd5,
		PH_ERROR = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        digit_seen;
		logic [16:0] acc;
		logic [31:0] addr;
	} parse_state_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] address;
		logic [15:0] port;
	} parse_res_t;

	localparam parse_state_t PARSE_STATE_RESET = '{
		phase:      PH_OCT0,
		digit_seen: 1'b0,
		acc:        17'd0,
		addr:       32'd0
	};

endpackage

/* design/ipv4p_ifs.sv */
// Request channels of the parser: characters in, parse results out.
interface ipv4p_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

interface ipv4p_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [31:0] address;
	logic [15:0] port;

	modport source (output valid, output valid_res, output address, output port, input ready);
	modport sink (input valid, input valid_res, input address, input port, output ready);
endinterface

/* design/ipv4p_step.sv */
// Next-state and result logic for one text character.
module ipv4p_step
	import ipv4p_pkg::*;
(
	input  parse_state_t cur,
	input  logic [7:0]   character,
	output parse_state_t nxt,
	output parse_res_t   res
);

	logic        is_digit;
	logic [19:0] prod;
	logic [16:0] acc_dig;
	logic        octet_ok;
	parse_state_t after_octet;

	assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	assign prod = ({3'b0, cur.acc} << 3) + ({3'b0, cur.acc} << 1) + {16'b0, character[3:0]};
	assign acc_dig = (prod > {3'b0, ACC_SAT}) ? ACC_SAT : prod[16:0];
	assign octet_ok = cur.digit_seen && (cur.acc <= OCTET_LIMIT);

	always_comb begin
		after_octet = cur;
		after_octet.addr = {cur.addr[23:0], cur.acc[7:0]};
		after_octet.acc = 17'd0;
		after_octet.digit_seen = 1'b0;
	end

	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_OCT0, PH_OCT1, PH_OCT2, PH_OCT3: begin
				if (is_digit) begin
					nxt.acc = acc_dig;
					nxt.digit_seen = 1'b1;
				end else if (!octet_ok) begin
					nxt.phase = PH_ERROR;
				end else begin
					nxt = after_octet;
					if (cur.phase == PH_OCT3) begin
						nxt.phase = (character == CHAR_COLON) ? PH_PORT : PH_DONE;
					end else begin
						nxt.phase = (character == CHAR_DOT) ? phase_t'(cur.phase + 3'd1)
							: PH_ERROR;
					end
				end
			end
			PH_PORT: begin
				if (is_digit) begin
					nxt.acc = acc_dig;
					nxt.digit_seen = 1'b1;
				end else begin
					nxt.phase = (cur.digit_seen && cur.acc <= PORT_LIMIT) ? PH_DONE : PH_ERROR;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res = '0;
		case (nxt.phase)
			PH_OCT3: begin
				if (nxt.digit_seen && nxt.acc <= OCTET_LIMIT) begin
					res.ok = 1'b1;
					res.address = {nxt.addr[23:0], nxt.acc[7:0]};
				end
			end
			PH_PORT: begin
				if (nxt.digit_seen && nxt.acc <= PORT_LIMIT) begin
					res.ok = 1'b1;
					res.address = nxt.addr;
					res.port = nxt.acc[15:0];
				end
			end
			PH_DONE: begin
				res.ok = 1'b1;
				res.address = nxt.addr;
				res.port = nxt.acc[15:0];
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

/* design/ipv4_dotted_text_parser.sv */
// Top level of the IPv4 dotted text parser with optional port.
//
//   channel  dir  payload                       request
//   chr      in   character[7:0], last          one text byte
//   res      out  valid_res, address[31:0],     one result per text
//                 port[15:0]
//
// One character is taken every cycle while chr.ready is high; the parse state
// update is a single multiply-by-ten add and phase step between the state and
// result registers. A result appears in the cycle after its last character is
// taken. arst_n clears the parse state and the result valid flag.
// chr.ready drops only while a result is held and res.ready is low.
`include "assert_macros.svh"

module ipv4_dotted_text_parser
	import ipv4p_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	ipv4p_char_if.sink  chr,
	ipv4p_res_if.source res
);

	parse_state_t st_q;
	parse_state_t st_nxt;
	parse_res_t   res_nxt;
	parse_res_t   res_q;
	logic         res_valid_q;
	logic         take;

	assign chr.ready = !res_valid_q || res.ready;
	assign take = chr.valid && chr.ready;

	ipv4p_step u_step (
		.cur       (st_q),
		.character (chr.character),
		.nxt       (st_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				st_q <= chr.last ? PARSE_STATE_RESET : st_nxt;
			end
			if (take && chr.last) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && chr.last) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid = res_valid_q;
	assign res.valid_res = res_q.ok;
	assign res.address = res_q.address;
	assign res.port = res_q.port;

	`ASSERT_SAME(a_err_zero, clk, arst_n, res.valid && !res.valid_res,
		res.address == 32'd0 && res.port == 16'd0)
	`ASSERT_NEXT(a_last_clears, clk, arst_n, take && chr.last,
		st_q == PARSE_STATE_RESET && res.valid)
	`ASSERT_NEXT(a_final_holds, clk, arst_n,
		(st_q.phase == PH_DONE || st_q.phase == PH_ERROR) && !(take && chr.last),
		$stable(st_q))

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the IPv4 dotted text parser: random and directed texts.
module testbench;
	import ipv4p_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEXT_CHARS  = 1250;
	localparam int QUIET_TAIL  = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 20;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	logic clk;
	logic arst_n;

	ipv4p_char_if chr();
	ipv4p_res_if  res();

	ipv4_dotted_text_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr),
		.res    (res)
	);

	char_req_t  pending_chars[$];
	logic [7:0] text_buf[$];
	parse_res_t expected_results[$];

	phase_t      prs_phase = PH_OCT0;
	logic        prs_digit = 1'b0;
	logic [16:0] prs_acc   = '0;
	logic [31:0] prs_addr  = '0;

	int n_errors    = 0;
	int n_cycles    = 0;
	int n_results   = 0;
	int src_gap     = 0;
	int snk_gap     = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit idling_allowed();
		return pending_chars.size() > QUIET_TAIL && ((n_cycles / 250) % 4) != 3;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		text_buf.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
	endtask

	task automatic put_number(input int unsigned v, input int zeros);
		repeat (zeros) put_byte(CHAR_ZERO);
		put_str($sformatf("%0d", v));
	endtask

	task automatic flush_text();
		char_req_t item;
		for (int i = 0; i < text_buf.size(); i++) begin
			item.ch = text_buf[i];
			item.last = (i == text_buf.size() - 1);
			pending_chars.push_back(item);
		end
		text_buf.delete();
	endtask

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 3))
			0: return CHAR_ZERO + 8'($urandom_range(0, 9));
			1: return CHAR_DOT;
			2: return CHAR_COLON;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned rand_octet();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			2: return $urandom_range(256, 999);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int unsigned rand_port();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return 65536;
			3: return $urandom_range(65537, 9999999);
			4: return $urandom_range(0, 99);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic add_random_text();
		int unsigned cut;
		if ($urandom_range(0, 9) < 7) begin
			for (int k = 0; k < 4; k++) begin
				if (k != 0) begin
					put_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : CHAR_DOT);
				end
				put_number(rand_octet(), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			end
			if ($urandom_range(0, 1) == 1) begin
				put_byte(CHAR_COLON);
				if ($urandom_range(0, 11) != 0) begin
					put_number(rand_port(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 5)) put_byte(rand_char());
			end
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, text_buf.size());
				while (text_buf.size() > cut) void'(text_buf.pop_back());
			end
		end else begin
			repeat ($urandom_range(1, 12)) put_byte(rand_char());
		end
		flush_text();
	endtask

	task automatic parse_char(input logic [7:0] c, input logic is_last);
		int unsigned v;
		parse_res_t r;
		if (prs_phase < PH_DONE) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				v = prs_acc * 10 + (c - CHAR_ZERO);
				prs_acc = (v > ACC_SAT) ? ACC_SAT : 17'(v);
				prs_digit = 1'b1;
			end else if (prs_phase == PH_PORT) begin
				prs_phase = (prs_digit && prs_acc <= PORT_LIMIT) ? PH_DONE : PH_ERROR;
			end else if (!prs_digit || prs_acc > OCTET_LIMIT) begin
				prs_phase = PH_ERROR;
			end else begin
				prs_addr = {prs_addr[23:0], prs_acc[7:0]};
				prs_acc = '0;
				prs_digit = 1'b0;
				if (prs_phase != PH_OCT3) begin
					prs_phase = (c == CHAR_DOT) ? phase_t'(prs_phase + 3'd1) : PH_ERROR;
				end else begin
					prs_phase = (c == CHAR_COLON) ? PH_PORT : PH_DONE;
				end
			end
		end
		if (is_last) begin
			r = '0;
			case (prs_phase)
				PH_OCT3: if (prs_digit && prs_acc <= OCTET_LIMIT) begin
					r.ok = 1'b1;
					r.address = {prs_addr[23:0], prs_acc[7:0]};
				end
				PH_PORT: if (prs_digit && prs_acc <= PORT_LIMIT) begin
					r.ok = 1'b1;
					r.address = prs_addr;
					r.port = prs_acc[15:0];
				end
				PH_DONE: begin
					r.ok = 1'b1;
					r.address = prs_addr;
					r.port = prs_acc[15:0];
				end
				default: ;
			endcase
			expected_results.push_back(r);
			prs_phase = PH_OCT0;
			prs_digit = 1'b0;
			prs_acc = '0;
			prs_addr = '0;
		end
	endtask

	always @(posedge clk) begin : drive_chars
		logic nv;
		if (arst_n) begin
			if (chr.valid && chr.ready) begin
				parse_char(chr.character, chr.last);
			end
			if (!(chr.valid && !chr.ready)) begin
				nv = 1'b0;
				if (src_gap != 0) begin
					src_gap = src_gap - 1;
				end else if (pending_chars.size() != 0) begin
					if (idling_allowed() && $urandom_range(0, 7) == 0) begin
						src_gap = $urandom_range(0, 10);
					end else begin
						chr.character <= pending_chars[0].ch;
						chr.last <= pending_chars[0].last;
						void'(pending_chars.pop_front());
						nv = 1'b1;
					end
				end
				chr.valid <= nv;
			end
		end
	end

	// hold off the result side once, long enough to back up the character side
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_results == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : drive_ready
		logic nr;
		if (arst_n) begin
			nr = 1'b1;
			if (hold_left != 0) begin
				nr = 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap = snk_gap - 1;
				nr = 1'b0;
			end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 10);
				nr = 1'b0;
			end
			res.ready <= nr;
		end
	end

	always @(posedge clk) begin : check_results
		parse_res_t want;
		if (arst_n && res.valid && res.ready) begin
			n_results <= n_results + 1;
			if (expected_results.size() == 0) begin
				$error("result with no pending text: valid_res=%0b address=%h port=%0d",
					res.valid_res, res.address, res.port);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (res.valid_res !== want.ok) begin
					$error("valid_res: expected %0b, actual %0b", want.ok, res.valid_res);
					n_errors++;
				end
				if (res.address !== want.address) begin
					$error("address: expected %h, actual %h", want.address, res.address);
					n_errors++;
				end
				if (res.port !== want.port) begin
					$error("port: expected %0d, actual %0d", want.port, res.port);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		chr.valid = 1'b0;
		chr.character = '0;
		chr.last = 1'b0;
		res.ready = 1'b0;

		put_str("0.0.0.0"); flush_text();
		put_str("255.255.255.255:65535"); flush_text();
		put_str("1.2.3.4:0"); flush_text();
		put_str("1.2.3.4"); flush_text();
		put_str("256.1.1.1"); flush_text();
		put_str("1.2.3.999"); flush_text();
		put_str("1.2.3.4:65536"); flush_text();
		put_str("1.2.3.4:99999999999"); flush_text();
		put_str("001.02.0003.0000255:00080"); flush_text();
		put_str("1..2.3"); flush_text();
		put_str(".1.2.3"); flush_text();
		put_str("1.2.3.4:"); flush_text();
		put_str("1.2.3.4:x"); flush_text();
		put_str("1.2,3.4"); flush_text();
		put_str("1.2.3"); flush_text();
		put_str("-1.2.3.4"); flush_text();
		put_str("10.0.0.1 rest"); flush_text();
		put_str("10.0.0.1:80/path"); flush_text();
		put_str("7"); flush_text();
		put_byte(8'hFF); flush_text();
		put_str("1.2.3.4"); put_byte(8'h00); put_byte(8'hFF); flush_text();
		while (pending_chars.size() < TEXT_CHARS) add_random_text();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() != 0 || chr.valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
